// ----- src/assert_macros.svh -----
// Assertion macros of the rolling hash search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- src/rhps_pkg.sv -----
// Shared constants, types and handshake structs of the rolling hash search.
package rhps_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int HASH_WIDTH      = 16;
   localparam int DIGIT_WIDTH     = 8;
   localparam int IDX_WIDTH       = $clog2(MAX_PATTERN);
   localparam int STEP_WIDTH      = $clog2(DIGIT_WIDTH);
   localparam int LEN_WIDTH       = 4;
   localparam int COUNT_WIDTH     = 32;
   localparam int CSR_WIDTH       = MAX_PATTERN * DIGIT_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [DIGIT_WIDTH-1:0]             byte_type;
   typedef logic [HASH_WIDTH-1:0]              hash_type;
   typedef logic [LEN_WIDTH-1:0]               len_type;
   typedef logic [IDX_WIDTH-1:0]               idx_type;
   typedef logic [STEP_WIDTH-1:0]              step_type;
   typedef logic [COUNT_WIDTH-1:0]             count_type;
   typedef logic [MAX_PATTERN*DIGIT_WIDTH-1:0] pattern_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS        = 2'd2;

   // Values after reset.
   localparam len_type  RESET_LENGTH  = 4'd1;
   localparam hash_type RESET_MODULUS = 16'd101;
   localparam hash_type HASH_ONE      = 16'd1;
   localparam hash_type MIN_MODULUS   = 16'd2;

   // Request to the serial modular unit: acc <- (acc * 256 + operand * factor) mod q.
   typedef struct packed {
      logic     start;
      hash_type acc_init;
      byte_type operand;
      hash_type factor;
   } smod_req_type;

   // Status of the serial modular unit; result is valid while done is high.
   typedef struct packed {
      logic     done;
      hash_type result;
   } smod_rsp_type;

endpackage

// ----- src/rhps_if.sv -----
// Request and response channel interfaces of the rolling hash search.
interface rhps_req_if
   import rhps_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type text_byte;
   logic     start_of_text;

   modport source (output valid, output text_byte, output start_of_text, input ready);
   modport sink (input valid, input text_byte, input start_of_text, output ready);
endinterface

interface rhps_rsp_if
   import rhps_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      match_found;
   logic      hash_equal;
   count_type match_start;

   modport source (output valid, output match_found, output hash_equal,
                   output match_start, input ready);
   modport sink (input valid, input match_found, input hash_equal,
                 input match_start, output ready);
endinterface

// ----- src/rolling_hash_pattern_search.sv -----
// Top level of the rolling hash pattern search over a stream of text bytes.
// Each request passes ST_LOAD, ST_MUL, ST_SUB, ST_APPEND and ST_FINISH; the response is registered.
// A new request is taken only back in ST_IDLE, after two passes of the serial modular unit.
// A configuration write rederives the hashes; no request is taken then.
// Reset is synchronous: pattern 0, length 1, modulus 101, window and counters cleared.
`include "assert_macros.svh"

module rolling_hash_pattern_search
   import rhps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   rhps_req_if.sink                   req_chan,
   rhps_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_write_data
);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'h0001,
      ST_LOAD     = 13'h0002,
      ST_MUL      = 13'h0004,
      ST_SUB      = 13'h0008,
      ST_APPEND   = 13'h0010,
      ST_FINISH   = 13'h0020,
      ST_CFG      = 13'h0040,
      ST_LP_ISSUE = 13'h0080,
      ST_LP_WAIT  = 13'h0100,
      ST_PH_ISSUE = 13'h0200,
      ST_PH_WAIT  = 13'h0400,
      ST_WH_ISSUE = 13'h0800,
      ST_WH_WAIT  = 13'h1000
   } state_type;

   state_type   state_ff, state_in;
   pattern_type pattern_ff, pattern_in;
   len_type     length_ff, length_in;
   hash_type    modulus_ff, modulus_in;
   hash_type    lead_ff, lead_in;
   hash_type    phash_ff, phash_in;
   hash_type    whash_ff, whash_in;
   count_type   seen_ff, seen_in;
   byte_type    byte_ff, byte_in;
   hash_type    dacc_ff, dacc_in;
   len_type     cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_match_ff, rsp_match_in;
   logic        rsp_heq_ff, rsp_heq_in;
   count_type   rsp_start_ff, rsp_start_in;

   len_type             m_eff;
   hash_type            q_eff;
   logic                full;
   len_type             filled;
   len_type             read_len;
   len_type             pat_pos;
   byte_type            pat_byte;
   logic [HASH_WIDTH:0] diff;
   hash_type            sub_result;
   logic                accept;
   logic                hash_hit;
   logic                hash_terms_reduced;

   smod_req_type smod_req;
   smod_rsp_type smod_rsp;
   logic         win_clear;
   logic         win_push;
   byte_type     read_byte;
   logic         pattern_equal;

   // Effective length and modulus after clamping.
   always_comb begin
      if (length_ff == '0) begin
         m_eff = len_type'(1);
      end else if (length_ff > len_type'(MAX_PATTERN)) begin
         m_eff = len_type'(MAX_PATTERN);
      end else begin
         m_eff = length_ff;
      end
      q_eff  = (modulus_ff < MIN_MODULUS) ? MIN_MODULUS : modulus_ff;
      full   = seen_ff >= count_type'(m_eff);
      filled = full ? m_eff : seen_ff[LEN_WIDTH-1:0];
   end

   // Window read address: the oldest byte for a request, a walk for derivation.
   always_comb begin
      if (state_ff == ST_WH_ISSUE || state_ff == ST_WH_WAIT) begin
         read_len = cnt_ff - len_type'(1);
      end else begin
         read_len = m_eff - len_type'(1);
      end
      pat_pos  = m_eff - cnt_ff;
      pat_byte = pattern_ff[DIGIT_WIDTH*pat_pos[IDX_WIDTH-1:0] +: DIGIT_WIDTH];
   end

   // Remove the leading term: (hash - product) mod q, both already reduced.
   always_comb begin
      diff       = {1'b0, whash_ff} - {1'b0, dacc_ff};
      sub_result = diff[HASH_WIDTH] ? diff[HASH_WIDTH-1:0] + q_eff : diff[HASH_WIDTH-1:0];
   end

   assign accept            = req_chan.valid && req_chan.ready;
   assign req_chan.ready    = (state_ff == ST_IDLE) && !csr_write_enable;
   assign hash_hit          = full && (whash_ff == phash_ff);

   // Main sequencer for requests and for derivation after a configuration write.
   always_comb begin
      state_in     = state_ff;
      pattern_in   = pattern_ff;
      length_in    = length_ff;
      modulus_in   = modulus_ff;
      lead_in      = lead_ff;
      phash_in     = phash_ff;
      whash_in     = whash_ff;
      seen_in      = seen_ff;
      byte_in      = byte_ff;
      dacc_in      = dacc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_match_in = rsp_match_ff;
      rsp_heq_in   = rsp_heq_ff;
      rsp_start_in = rsp_start_ff;
      win_clear    = 1'b0;
      win_push     = 1'b0;
      smod_req.start    = 1'b0;
      smod_req.acc_init = dacc_ff;
      smod_req.operand  = '0;
      smod_req.factor   = HASH_ONE;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in  = req_chan.text_byte;
               state_in = ST_LOAD;
               if (req_chan.start_of_text) begin
                  win_clear = 1'b1;
                  whash_in  = '0;
                  seen_in   = '0;
               end
            end
         end
         // Product of the leaving byte and the leading power.
         ST_LOAD: begin
            smod_req.start    = 1'b1;
            smod_req.acc_init = '0;
            smod_req.operand  = full ? read_byte : '0;
            smod_req.factor   = lead_ff;
            state_in          = ST_MUL;
         end
         ST_MUL: begin
            if (smod_rsp.done) begin
               dacc_in  = smod_rsp.result;
               state_in = ST_SUB;
            end
         end
         // Append the new byte to the reduced hash.
         ST_SUB: begin
            smod_req.start    = 1'b1;
            smod_req.acc_init = sub_result;
            smod_req.operand  = byte_ff;
            state_in          = ST_APPEND;
         end
         ST_APPEND: begin
            if (smod_rsp.done) begin
               whash_in = smod_rsp.result;
               win_push = 1'b1;
               if (seen_ff != '1) begin
                  seen_in = seen_ff + 1'b1;
               end
               state_in = ST_FINISH;
            end
         end
         // Hand the response to the output register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_heq_in   = hash_hit;
               rsp_match_in = hash_hit && pattern_equal;
               rsp_start_in = full ? seen_ff - count_type'(m_eff) : '0;
               state_in     = ST_IDLE;
            end
         end
         ST_CFG: begin
            dacc_in  = HASH_ONE;
            cnt_in   = m_eff - len_type'(1);
            state_in = ST_LP_ISSUE;
         end
         // Leading power: 1 shifted by m-1 zero bytes.
         ST_LP_ISSUE: begin
            if (cnt_ff == '0) begin
               lead_in  = dacc_ff;
               dacc_in  = '0;
               cnt_in   = m_eff;
               state_in = ST_PH_ISSUE;
            end else begin
               smod_req.start = 1'b1;
               state_in       = ST_LP_WAIT;
            end
         end
         ST_LP_WAIT: begin
            if (smod_rsp.done) begin
               dacc_in  = smod_rsp.result;
               cnt_in   = cnt_ff - len_type'(1);
               state_in = ST_LP_ISSUE;
            end
         end
         // Pattern hash, first byte first.
         ST_PH_ISSUE: begin
            if (cnt_ff == '0) begin
               phash_in = dacc_ff;
               dacc_in  = '0;
               cnt_in   = filled;
               state_in = ST_WH_ISSUE;
            end else begin
               smod_req.start   = 1'b1;
               smod_req.operand = pat_byte;
               state_in         = ST_PH_WAIT;
            end
         end
         ST_PH_WAIT: begin
            if (smod_rsp.done) begin
               dacc_in  = smod_rsp.result;
               cnt_in   = cnt_ff - len_type'(1);
               state_in = ST_PH_ISSUE;
            end
         end
         // Window hash over the filled part, oldest byte first.
         ST_WH_ISSUE: begin
            if (cnt_ff == '0) begin
               whash_in = dacc_ff;
               state_in = ST_IDLE;
            end else begin
               smod_req.start   = 1'b1;
               smod_req.operand = read_byte;
               state_in         = ST_WH_WAIT;
            end
         end
         ST_WH_WAIT: begin
            if (smod_rsp.done) begin
               dacc_in  = smod_rsp.result;
               cnt_in   = cnt_ff - len_type'(1);
               state_in = ST_WH_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts derivation from the new settings.
      // A write to an unknown index leaves everything as it is.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_BYTES: begin
               pattern_in = csr_write_data;
               state_in   = ST_CFG;
            end
            CSR_PATTERN_LENGTH: begin
               length_in = csr_write_data[LEN_WIDTH-1:0];
               state_in  = ST_CFG;
            end
            CSR_MODULUS: begin
               modulus_in = csr_write_data[HASH_WIDTH-1:0];
               state_in   = ST_CFG;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pattern_ff   <= '0;
         length_ff    <= RESET_LENGTH;
         modulus_ff   <= RESET_MODULUS;
         lead_ff      <= HASH_ONE;
         phash_ff     <= '0;
         whash_ff     <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pattern_ff   <= pattern_in;
         length_ff    <= length_in;
         modulus_ff   <= modulus_in;
         lead_ff      <= lead_in;
         phash_ff     <= phash_in;
         whash_ff     <= whash_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      dacc_ff      <= dacc_in;
      cnt_ff       <= cnt_in;
      rsp_match_ff <= rsp_match_in;
      rsp_heq_ff   <= rsp_heq_in;
      rsp_start_ff <= rsp_start_in;
   end

   rhps_serial_mod u_serial_mod (
      .clock    (clock),
      .reset    (reset),
      .modulus  (q_eff),
      .smod_req (smod_req),
      .smod_rsp (smod_rsp)
   );

   rhps_window u_window (
      .clock         (clock),
      .reset         (reset),
      .clear         (win_clear),
      .push          (win_push),
      .push_byte     (byte_ff),
      .read_index    (read_len[IDX_WIDTH-1:0]),
      .read_byte     (read_byte),
      .length        (m_eff),
      .pattern       (pattern_ff),
      .pattern_equal (pattern_equal)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_found = rsp_match_ff;
   assign rsp_chan.hash_equal  = rsp_heq_ff;
   assign rsp_chan.match_start = rsp_start_ff;

   // All stored hash terms stay reduced whenever the block waits for a request.
   assign hash_terms_reduced = (whash_ff < q_eff) && (lead_ff < q_eff) && (phash_ff < q_eff);
   `ASSERT_IMPLY(a_hash_reduced, state_ff == ST_IDLE, hash_terms_reduced)
   // A verified match is always also a hash hit.
   `ASSERT_IMPLY(a_match_has_hash, rsp_valid_ff, !rsp_match_ff || rsp_heq_ff)
   // An accepted request always starts the leaving-byte product next.
   `ASSERT_NEXT(a_accept_loads, accept, state_ff == ST_LOAD)

endmodule

// ----- src/rhps_serial_mod.sv -----
// Bit-serial modular multiply-accumulate unit, one operand bit per cycle.
module rhps_serial_mod
   import rhps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_type     modulus,
   input  smod_req_type smod_req,
   output smod_rsp_type smod_rsp
);

   logic     busy_ff, busy_in;
   logic     done_ff, done_in;
   step_type step_ff, step_in;
   hash_type acc_ff, acc_in;
   hash_type factor_ff, factor_in;
   byte_type digit_ff, digit_in;

   logic [HASH_WIDTH:0] doubled;
   logic [HASH_WIDTH:0] reduced;
   logic [HASH_WIDTH:0] summed;
   logic [HASH_WIDTH:0] wide_mod;
   hash_type            addend;
   hash_type            folded;

   // One Horner step: double, reduce, add factor when the bit is set, reduce.
   always_comb begin
      wide_mod = {1'b0, modulus};
      doubled  = {acc_ff, 1'b0};
      reduced  = (doubled >= wide_mod) ? doubled - wide_mod : doubled;
      addend   = digit_ff[DIGIT_WIDTH-1] ? factor_ff : '0;
      summed   = reduced + {1'b0, addend};
      folded   = (summed >= wide_mod) ? hash_type'(summed - wide_mod)
                                      : summed[HASH_WIDTH-1:0];
   end

   // Sequencing: load on start, then one bit per cycle, MSB first.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      acc_in    = acc_ff;
      factor_in = factor_ff;
      digit_in  = digit_ff;
      if (smod_req.start) begin
         busy_in   = 1'b1;
         step_in   = '0;
         acc_in    = smod_req.acc_init;
         factor_in = smod_req.factor;
         digit_in  = smod_req.operand;
      end else if (busy_ff) begin
         acc_in   = folded;
         digit_in = {digit_ff[DIGIT_WIDTH-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_WIDTH'(DIGIT_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      factor_ff <= factor_in;
      digit_ff  <= digit_in;
   end

   assign smod_rsp.done   = done_ff;
   assign smod_rsp.result = acc_ff;

endmodule

// ----- src/rhps_window.sv -----
// Window of recent text bytes with one read port and a pattern comparator.
module rhps_window
   import rhps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        push,
   input  byte_type    push_byte,
   input  idx_type     read_index,
   output byte_type    read_byte,
   input  len_type     length,
   input  pattern_type pattern,
   output logic        pattern_equal
);

   byte_type window_ff [MAX_PATTERN];
   byte_type window_in [MAX_PATTERN];

   // Entry zero holds the newest byte; a push moves everything one place.
   always_comb begin
      window_in = window_ff;
      if (clear) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_in[i] = '0;
         end
      end else if (push) begin
         for (int i = MAX_PATTERN - 1; i > 0; i--) begin
            window_in[i] = window_ff[i-1];
         end
         window_in[0] = push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         window_ff <= window_in;
      end
   end

   assign read_byte = window_ff[read_index];

   // Entry i of the window lines up with pattern byte length-1-i.
   always_comb begin
      len_type pos;
      pattern_equal = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pos = length - len_type'(i) - len_type'(1);
         if ((len_type'(i) < length) &&
             (window_ff[i] != pattern[DIGIT_WIDTH*pos[IDX_WIDTH-1:0] +: DIGIT_WIDTH])) begin
            pattern_equal = 1'b0;
         end
      end
   end

endmodule

// ----- tb/sv/tb_rolling_hash_pattern_search.sv -----
// Self-checking testbench of the rolling hash pattern search with its own response predictor.
module tb_rolling_hash_pattern_search
   import rhps_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Wait after a configuration write while the hashes are rederived, with a margin.
   localparam int SETTLE_CYCLES   = 10 * (3 * MAX_PATTERN - 1) + 30;
   localparam int DRAIN_CYCLES    = 40;
   localparam int IDLE_LIMIT      = 4000;
   localparam int MAX_GAP         = 6;
   localparam int DIRECTED_ROWS   = 31;
   localparam int RANDOM_PHASES   = 25;
   localparam int PHASE_REQUESTS  = 50;

   typedef struct packed {
      logic      match_found;
      logic      hash_equal;
      count_type match_start;
   } search_result_type;

   typedef enum logic {ROW_TEXT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_WIDTH-1:0]       data;
      byte_type                   text;
      logic                       sot;
      logic                       known;
      search_result_type          result;
   } directed_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]       csr_write_data;

   rhps_req_if req_chan ();
   rhps_rsp_if rsp_chan ();

   rolling_hash_pattern_search DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Configuration and state of the predicted search.
   pattern_type cfg_pattern;
   len_type     cfg_length;
   hash_type    cfg_modulus;
   byte_type    window_bytes [MAX_PATTERN];
   hash_type    window_hash;
   hash_type    pattern_hash;
   hash_type    leading_power;
   count_type   seen_count;

   search_result_type pending_results [$];
   directed_row_type  directed_rows [DIRECTED_ROWS];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                rsp_stall_left = 0;
   logic              req_idle_on = 1'b1;
   logic              rsp_idle_on = 1'b1;
   logic              narrow_text = 1'b0;

   function automatic int active_length();
      if (cfg_length == 0) return 1;
      if (cfg_length > MAX_PATTERN) return MAX_PATTERN;
      return int'(cfg_length);
   endfunction

   function automatic longint unsigned active_modulus();
      return (cfg_modulus < MIN_MODULUS) ? 64'd2 : 64'(cfg_modulus);
   endfunction

   function automatic byte_type pattern_digit(int j);
      return cfg_pattern[8 * (j % MAX_PATTERN) +: 8];
   endfunction

   // Recompute the power term, the pattern hash and the hash of the filled part of the window.
   function automatic void rederive_hashes();
      int                m;
      int                filled;
      int                j;
      longint unsigned   q;
      longint unsigned   pw;
      longint unsigned   ph;
      longint unsigned   wh;
      m = active_length();
      q = active_modulus();
      filled = (seen_count < m) ? int'(seen_count) : m;
      pw = 1 % q;
      for (j = 0; j + 1 < m; j++) pw = (pw * 256) % q;
      ph = 0;
      for (j = 0; j < m; j++) ph = (ph * 256 + pattern_digit(j)) % q;
      wh = 0;
      for (j = filled; j > 0; j--) wh = (wh * 256 + window_bytes[j - 1]) % q;
      leading_power = hash_type'(pw);
      pattern_hash  = hash_type'(ph);
      window_hash   = hash_type'(wh);
   endfunction

   function automatic void reset_search();
      cfg_pattern  = '0;
      cfg_length   = RESET_LENGTH;
      cfg_modulus  = RESET_MODULUS;
      window_bytes = '{default: '0};
      seen_count   = '0;
      rederive_hashes();
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                          logic [CSR_WIDTH-1:0] value);
      case (index)
         CSR_PATTERN_BYTES:  cfg_pattern = value;
         CSR_PATTERN_LENGTH: cfg_length  = value[LEN_WIDTH-1:0];
         CSR_MODULUS:        cfg_modulus = value[HASH_WIDTH-1:0];
         default:            return;
      endcase
      rederive_hashes();
   endfunction

   // Roll one text byte into the window and work out its response.
   function automatic search_result_type roll_window(byte_type text, logic sot);
      int                m;
      int                j;
      longint unsigned   q;
      longint unsigned   oldest;
      longint unsigned   t;
      search_result_type r;
      m = active_length();
      q = active_modulus();
      if (sot) begin
         window_bytes = '{default: '0};
         window_hash  = '0;
         seen_count   = '0;
      end
      oldest = (seen_count >= m) ? 64'(window_bytes[m - 1]) : 64'd0;
      t = window_hash % q;
      t = (t + q - (oldest * leading_power) % q) % q;
      t = (t * 256 + text) % q;
      window_hash = hash_type'(t);
      for (j = MAX_PATTERN - 1; j > 0; j--) window_bytes[j] = window_bytes[j - 1];
      window_bytes[0] = text;
      if (seen_count != '1) seen_count++;
      r = '0;
      if (seen_count >= m) begin
         r.match_start = seen_count - count_type'(m);
         r.hash_equal  = (window_hash == pattern_hash);
         if (r.hash_equal) begin
            r.match_found = 1'b1;
            for (j = 0; j < m; j++)
               if (window_bytes[m - 1 - j] != pattern_digit(j)) r.match_found = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic directed_row_type known_row(byte_type text, logic sot, logic match,
                                                  logic heq, count_type start);
      directed_row_type row;
      row        = '0;
      row.kind   = ROW_TEXT;
      row.text   = text;
      row.sot    = sot;
      row.known  = 1'b1;
      row.result = '{match, heq, start};
      return row;
   endfunction

   function automatic directed_row_type open_row(byte_type text, logic sot);
      directed_row_type row;
      row      = '0;
      row.kind = ROW_TEXT;
      row.text = text;
      row.sot  = sot;
      return row;
   endfunction

   function automatic directed_row_type csr_row(logic [CSR_INDEX_WIDTH-1:0] index,
                                                logic [CSR_WIDTH-1:0] data);
      directed_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = index;
      row.data  = data;
      return row;
   endfunction

   function automatic byte_type random_text_byte();
      if (narrow_text) return $urandom_range(0, 1) ? 8'h62 : 8'h61;
      return byte_type'($urandom_range(0, 255));
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Send one text request, after a random gap when req_idle_on is set; the caller stands at a falling edge.
   task automatic send_text_byte(input byte_type text, input logic sot, input logic known,
                                 input search_result_type known_result);
      int                gap;
      search_result_type predicted;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.text_byte     = text;
      req_chan.start_of_text = sot;
      do @(posedge clock); while (!req_chan.ready);
      predicted = roll_window(text, sot);
      pending_results.insert(pending_results.size(), known ? known_result : predicted);
      @(negedge clock);
   endtask

   // Write one register once every response is in and the block has settled.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_WIDTH-1:0] value);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      apply_register(index, value);
   endtask

   // Pick a new setting, extremes and out-of-range codes included, and write every register.
   task automatic configure_random();
      pattern_type pat;
      len_type     len;
      hash_type    q;
      int          k;
      case ($urandom_range(0, 9))
         0:       pat = '0;
         1:       pat = '1;
         default: for (k = 0; k < MAX_PATTERN; k++) pat[8 * k +: 8] = random_text_byte();
      endcase
      case ($urandom_range(0, 11))
         0:       len = '0;
         1:       len = len_type'($urandom_range(MAX_PATTERN + 1, 15));
         2:       len = len_type'(MAX_PATTERN);
         3:       len = 4'd1;
         default: len = len_type'($urandom_range(1, MAX_PATTERN));
      endcase
      case ($urandom_range(0, 7))
         0:       q = hash_type'($urandom_range(0, 1));
         1:       q = 16'd65535;
         2:       q = hash_type'($urandom_range(2, 7));
         3:       q = 16'd101;
         4:       q = 16'd65521;
         5:       q = 16'd251;
         default: q = hash_type'($urandom_range(2, 65535));
      endcase
      write_register(CSR_PATTERN_BYTES, pat);
      write_register(CSR_PATTERN_LENGTH, CSR_WIDTH'(len));
      write_register(CSR_MODULUS, CSR_WIDTH'(q));
   endtask

   // Mostly whole copies of the pattern, some with one byte broken, the rest loose bytes.
   task automatic run_random_phase(input int budget);
      int       sent;
      int       m;
      int       k;
      int       bad;
      int       choice;
      byte_type text;
      sent = 0;
      m = active_length();
      while (sent < budget) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            bad = (choice < 5) ? -1 : $urandom_range(0, m - 1);
            for (k = 0; k < m; k++) begin
               text = pattern_digit(k);
               if (k == bad) text = text ^ (8'h01 << $urandom_range(0, 7));
               send_text_byte(text, (k == 0) && ($urandom_range(0, 15) == 0), 1'b0, '0);
               sent++;
            end
         end else begin
            send_text_byte(random_text_byte(), $urandom_range(0, 29) == 0, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // Response side: compare each response with the oldest expectation, then draw a new stall.
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request pending: match_start %0d", rsp_chan.match_start);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("match_found", 32'(want.match_found), 32'(rsp_chan.match_found));
            check_field("hash_equal", 32'(want.hash_equal), 32'(rsp_chan.hash_equal));
            check_field("match_start", want.match_start, rsp_chan.match_start);
         end
         rsp_stall_left = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
   end

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // Watchdog: end the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int r;
      int phase;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.text_byte     = '0;
      req_chan.start_of_text = 1'b0;
      rsp_chan.ready         = 1'b0;
      csr_write_enable       = 1'b0;
      csr_index              = '0;
      csr_write_data         = '0;
      reset_search();

      directed_rows = '{
         // Reset setting: pattern zero, length one, modulus 101.
         known_row(8'h00, 1'b1, 1'b1, 1'b1, 0),
         // 101 folds to zero: the hashes agree but the bytes do not.
         known_row(8'h65, 1'b0, 1'b0, 1'b1, 1),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 2),
         known_row(8'h00, 1'b1, 1'b1, 1'b1, 0),
         // Three-byte pattern under the largest modulus; flags stay low while the window fills.
         csr_row(CSR_PATTERN_BYTES, 64'h0000_0000_0063_6261),
         csr_row(CSR_PATTERN_LENGTH, 64'd3),
         csr_row(CSR_MODULUS, 64'd65535),
         known_row(8'h61, 1'b1, 1'b0, 1'b0, 0),
         known_row(8'h62, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'h63, 1'b0, 1'b1, 1'b1, 0),
         open_row(8'h61, 1'b0),
         open_row(8'h62, 1'b0),
         open_row(8'h63, 1'b0),
         // Mid-stream change to a modulus below the minimum, then a zero length.
         csr_row(CSR_MODULUS, 64'd1),
         open_row(8'h61, 1'b0),
         open_row(8'h80, 1'b0),
         csr_row(CSR_PATTERN_LENGTH, 64'd0),
         open_row(8'h61, 1'b0),
         open_row(8'h63, 1'b0),
         // All-ones pattern, length above the maximum, modulus zero.
         csr_row(CSR_PATTERN_BYTES, '1),
         csr_row(CSR_PATTERN_LENGTH, 64'd15),
         csr_row(CSR_MODULUS, 64'd0),
         known_row(8'hFF, 1'b1, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b0, 1'b0, 0),
         known_row(8'hFF, 1'b0, 1'b1, 1'b1, 0),
         open_row(8'h00, 1'b0)
      };

      repeat (9) @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_register(directed_rows[r].index, directed_rows[r].data);
         end else begin
            send_text_byte(directed_rows[r].text, directed_rows[r].sot,
                           directed_rows[r].known, directed_rows[r].result);
         end
      end

      // Random phases, each under a fresh setting; the text stream carries over between them.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         narrow_text = ($urandom_range(0, 2) == 0);
         configure_random();
         run_random_phase(PHASE_REQUESTS);
      end

      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
